### rtl/bfcp_pkg.sv
// shared types and constants of the brace framed command parser
// no dependencies; imported by bfcp_atoi and brace_framed_command_parser_core
package bfcp_pkg;

    // result kinds
    localparam logic [3:0] KIND_INFO   = 4'd0;
    localparam logic [3:0] KIND_TAG    = 4'd1;
    localparam logic [3:0] KIND_WR8    = 4'd2;
    localparam logic [3:0] KIND_RD8    = 4'd3;
    localparam logic [3:0] KIND_WR1    = 4'd4;
    localparam logic [3:0] KIND_RD1    = 4'd5;
    localparam logic [3:0] KIND_WRTEXT = 4'd6;
    localparam logic [3:0] KIND_RDTEXT = 4'd7;
    localparam logic [3:0] KIND_ERR    = 4'd8;

    // framing and number characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // two-character command names
    localparam logic [15:0] NAME_DD = 16'h4444;
    localparam logic [15:0] NAME_DT = 16'h4454;
    localparam logic [15:0] NAME_WA = 16'h2141;
    localparam logic [15:0] NAME_RA = 16'h3F41;
    localparam logic [15:0] NAME_WB = 16'h2142;
    localparam logic [15:0] NAME_RB = 16'h3F42;
    localparam logic [15:0] NAME_WC = 16'h2143;
    localparam logic [15:0] NAME_RC = 16'h3F43;

endpackage

### rtl/bfcp_atoi.sv
// streaming decimal parser: one field byte per step, atoi semantics, wraps mod 2^16
// depends on bfcp_pkg
module bfcp_atoi
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        step,
    input  logic [7:0]  ch,
    output logic [15:0] value,
    output logic        nonzero
);
    import bfcp_pkg::*;

    typedef enum logic [2:0]
    {
        P_WS  = 3'b001,
        P_DIG = 3'b010,
        P_END = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        nz_reg, nz_next;
    logic        is_ws, is_digit, is_sign;
    logic [3:0]  digit;
    logic [7:0]  diff;
    logic [15:0] acc_step;

    assign is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign diff     = ch - CH_ZERO;
    assign digit    = diff[3:0];
    // acc * 10 + digit as two shifted adds
    assign acc_step = {acc_reg[12:0], 3'b000} + {acc_reg[14:0], 1'b0} + {12'd0, digit};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        nz_next    = nz_reg;
        if (clear)
        begin
            phase_next = P_WS;
            acc_next   = '0;
            neg_next   = 1'b0;
            nz_next    = 1'b0;
        end
        else if (step)
        begin
            unique case (phase_reg)
                P_WS:
                begin
                    if (is_ws)
                    begin
                        phase_next = P_WS;
                    end
                    else if (is_sign)
                    begin
                        neg_next   = (ch == CH_MINUS);
                        phase_next = P_DIG;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = acc_step;
                        nz_next    = nz_reg || (digit != 4'd0);
                        phase_next = P_DIG;
                    end
                    else
                    begin
                        phase_next = P_END;
                    end
                end
                P_DIG:
                begin
                    if (is_digit)
                    begin
                        acc_next = acc_step;
                        nz_next  = nz_reg || (digit != 4'd0);
                    end
                    else
                    begin
                        phase_next = P_END;
                    end
                end
                P_END:
                begin
                    phase_next = P_END;
                end
                default:
                begin
                    phase_next = P_END;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_WS;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            nz_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            nz_reg    <= nz_next;
        end
    end

    assign value   = neg_reg ? (16'd0 - acc_reg) : acc_reg;
    assign nonzero = nz_reg;

endmodule

### rtl/brace_framed_command_parser_core.sv
// brace framed command parser: bytes are buffered in a frame memory with one write and
// one read port; a '}' starts a walk that reads back bytes 1..len-2 (memory read, then
// field processing for each byte), then a decode state, then the results: one per payload
// byte for a non-empty tag or text write (memory read, then output load), else a single result.
// one byte is taken per cycle while idle, none during the walk and the emission of its results.
// asynchronous active-low reset empties the frame; the memory itself is not cleared.
module brace_framed_command_parser_core
#(
    parameter int FRAME_BYTES = 64,
    parameter int TAG_BYTES   = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [15:0] channel,
    output logic [7:0]  data_value,
    output logic [7:0]  text_byte,
    output logic        text_valid,
    output logic        last
);
    import bfcp_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int TW = $clog2(TAG_BYTES);
    localparam int LW = (AW > TW) ? AW : TW;
    localparam logic [TW-1:0] TAG_MAX = TW'(TAG_BYTES - 1);

    typedef enum logic [6:0]
    {
        S_IDLE      = 7'b0000001,
        S_SCAN_RD   = 7'b0000010,
        S_SCAN_PROC = 7'b0000100,
        S_DECIDE    = 7'b0001000,
        S_EMIT_RD   = 7'b0010000,
        S_EMIT_WR   = 7'b0100000,
        S_SINGLE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // frame memory
    logic [7:0]    mem [FRAME_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] raddr, waddr;
    logic          we;

    logic [CW-1:0] fill_reg;
    logic          head_reg;

    // scan state
    logic [AW-1:0] pos_reg, last_pos_reg;
    logic [1:0]    fld_reg;
    logic          stop_reg;
    logic [1:0]    slen0_reg;
    logic          term0_reg, term1_reg;
    logic [7:0]    b0_reg, b1_reg;
    logic [TW-1:0] tl_reg;
    logic [AW-1:0] fs1_reg, fs2_reg, fl2_reg;

    // decoded command
    logic [3:0]    kind_reg, kind_next;
    logic [15:0]   ch_reg;
    logic [7:0]    val_reg;
    logic [AW-1:0] base_reg;
    logic [LW-1:0] cnt_reg, idx_reg, idx_inc;

    // output register
    logic          out_valid_reg;
    logic [3:0]    o_kind_reg;
    logic [15:0]   o_ch_reg;
    logic [7:0]    o_val_reg, o_text_reg;
    logic          o_tv_reg, o_last_reg;

    logic          accept, is_open, is_close, start_scan, slot_free;
    logic [AW-1:0] widx;
    logic [CW-1:0] wfill, len_m2;
    logic          head_now, scan_byte, is_hash;
    logic [15:0]   a1_value, a2_value;
    logic          a1_nz, a2_nz;
    logic          step1, step2;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_open   = (rx_byte == CH_LBRACE);
    assign is_close  = (rx_byte == CH_RBRACE);
    // a full buffer is dropped before the next byte is stored
    assign widx      = (fill_reg >= CW'(FRAME_BYTES)) ? '0 : fill_reg[AW-1:0];
    assign wfill     = CW'(widx) + CW'(1);
    assign len_m2    = wfill - CW'(2);
    assign head_now  = head_reg && (widx != '0);
    assign start_scan = accept && is_close && head_now && (wfill >= CW'(3));
    assign slot_free = !out_valid_reg || out_ready;

    assign we    = accept;
    assign waddr = is_open ? '0 : widx;
    assign raddr = ((state_reg == S_SCAN_RD) || (state_reg == S_SCAN_PROC))
                   ? pos_reg : (base_reg + AW'(idx_reg));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= rx_byte;
        end
        rdata_reg <= mem[raddr];
    end

    // field walk
    assign is_hash   = (rdata_reg == CH_HASH);
    assign scan_byte = (state_reg == S_SCAN_PROC) && !stop_reg && !is_hash;
    assign step1     = scan_byte && (fld_reg == 2'd1);
    assign step2     = scan_byte && (fld_reg == 2'd2);

    bfcp_atoi u_atoi_ch
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (start_scan),
        .step    (step1),
        .ch      (rdata_reg),
        .value   (a1_value),
        .nonzero (a1_nz)
    );

    bfcp_atoi u_atoi_val
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (start_scan),
        .step    (step2),
        .ch      (rdata_reg),
        .value   (a2_value),
        .nonzero (a2_nz)
    );

    // command decode: exact name and exact field count
    always_comb
    begin
        kind_next = KIND_ERR;
        if (slen0_reg == 2'd2)
        begin
            unique case ({b0_reg, b1_reg})
                NAME_DD: if (fld_reg == 2'd0) kind_next = KIND_INFO;
                NAME_DT: if (fld_reg == 2'd1) kind_next = KIND_TAG;
                NAME_WA: if (fld_reg == 2'd2) kind_next = KIND_WR8;
                NAME_RA: if (fld_reg == 2'd1) kind_next = KIND_RD8;
                NAME_WB: if (fld_reg == 2'd2) kind_next = KIND_WR1;
                NAME_RB: if (fld_reg == 2'd1) kind_next = KIND_RD1;
                NAME_WC: if (fld_reg == 2'd2) kind_next = KIND_WRTEXT;
                NAME_RC: if (fld_reg == 2'd1) kind_next = KIND_RDTEXT;
                default: kind_next = KIND_ERR;
            endcase
        end
    end

    assign idx_inc = idx_reg + LW'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (start_scan) state_next = S_SCAN_RD;
            S_SCAN_RD:   state_next = S_SCAN_PROC;
            S_SCAN_PROC: state_next = (pos_reg == last_pos_reg) ? S_DECIDE : S_SCAN_RD;
            S_DECIDE:
            begin
                if (((kind_next == KIND_TAG) && (tl_reg != '0)) ||
                    ((kind_next == KIND_WRTEXT) && (fl2_reg != '0)))
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_SINGLE;
                end
            end
            S_EMIT_RD:   state_next = S_EMIT_WR;
            S_EMIT_WR:
            begin
                if (slot_free)
                begin
                    state_next = (idx_inc == cnt_reg) ? S_IDLE : S_EMIT_RD;
                end
            end
            S_SINGLE:    if (slot_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            head_reg      <= 1'b0;
            pos_reg       <= '0;
            last_pos_reg  <= '0;
            fld_reg       <= '0;
            stop_reg      <= 1'b0;
            slen0_reg     <= '0;
            term0_reg     <= 1'b0;
            term1_reg     <= 1'b0;
            tl_reg        <= '0;
            fs1_reg       <= '0;
            fs2_reg       <= '0;
            fl2_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_open)
                        begin
                            fill_reg <= CW'(1);
                            head_reg <= 1'b1;
                        end
                        else
                        begin
                            if (widx == '0)
                            begin
                                head_reg <= 1'b0;
                            end
                            fill_reg <= is_close ? '0 : wfill;
                        end
                    end
                    if (start_scan)
                    begin
                        pos_reg      <= AW'(1);
                        last_pos_reg <= AW'(len_m2);
                        fld_reg      <= '0;
                        stop_reg     <= 1'b0;
                        slen0_reg    <= '0;
                        term0_reg    <= 1'b0;
                        term1_reg    <= 1'b0;
                        tl_reg       <= '0;
                        fs1_reg      <= '0;
                        fs2_reg      <= '0;
                        fl2_reg      <= '0;
                    end
                end
                S_SCAN_PROC:
                begin
                    pos_reg <= pos_reg + AW'(1);
                    if (!stop_reg)
                    begin
                        if (is_hash)
                        begin
                            // bytes after a third separator are ignored
                            if (fld_reg == 2'd2)
                            begin
                                stop_reg <= 1'b1;
                            end
                            else
                            begin
                                fld_reg <= fld_reg + 2'd1;
                                if (fld_reg == 2'd0)
                                begin
                                    fs1_reg <= pos_reg + AW'(1);
                                end
                                else
                                begin
                                    fs2_reg <= pos_reg + AW'(1);
                                end
                            end
                        end
                        else
                        begin
                            case (fld_reg)
                                2'd0:
                                begin
                                    if (!term0_reg)
                                    begin
                                        if (rdata_reg == CH_NUL)
                                        begin
                                            term0_reg <= 1'b1;
                                        end
                                        else
                                        begin
                                            if (slen0_reg == 2'd0) b0_reg <= rdata_reg;
                                            if (slen0_reg == 2'd1) b1_reg <= rdata_reg;
                                            if (slen0_reg != 2'd3) slen0_reg <= slen0_reg + 2'd1;
                                        end
                                    end
                                end
                                2'd1:
                                begin
                                    // tag length: string length capped at the tag limit
                                    if (!term1_reg)
                                    begin
                                        if (rdata_reg == CH_NUL)
                                        begin
                                            term1_reg <= 1'b1;
                                        end
                                        else if (tl_reg != TAG_MAX)
                                        begin
                                            tl_reg <= tl_reg + TW'(1);
                                        end
                                    end
                                end
                                2'd2:
                                begin
                                    fl2_reg <= fl2_reg + AW'(1);
                                end
                                default:
                                begin
                                    stop_reg <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_DECIDE:
                begin
                    kind_reg <= kind_next;
                    idx_reg  <= '0;
                    case (kind_next)
                        KIND_WR8, KIND_RD8, KIND_WR1, KIND_RD1, KIND_WRTEXT, KIND_RDTEXT:
                            ch_reg <= a1_value;
                        default:
                            ch_reg <= '0;
                    endcase
                    if (kind_next == KIND_WR8)
                    begin
                        val_reg <= a2_value[7:0];
                    end
                    else if (kind_next == KIND_WR1)
                    begin
                        val_reg <= {7'd0, a2_nz};
                    end
                    else
                    begin
                        val_reg <= '0;
                    end
                    if (kind_next == KIND_TAG)
                    begin
                        base_reg <= fs1_reg;
                        cnt_reg  <= LW'(tl_reg);
                    end
                    else
                    begin
                        base_reg <= fs2_reg;
                        cnt_reg  <= LW'(fl2_reg);
                    end
                end
                S_EMIT_WR:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_kind_reg    <= kind_reg;
                        o_ch_reg      <= ch_reg;
                        o_val_reg     <= val_reg;
                        o_text_reg    <= rdata_reg;
                        o_tv_reg      <= 1'b1;
                        o_last_reg    <= (idx_inc == cnt_reg);
                        idx_reg       <= idx_inc;
                    end
                end
                S_SINGLE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_kind_reg    <= kind_reg;
                        o_ch_reg      <= ch_reg;
                        o_val_reg     <= val_reg;
                        o_text_reg    <= '0;
                        o_tv_reg      <= 1'b0;
                        o_last_reg    <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // a1_nz is not part of any result; channel only needs the value
    logic unused_nz;
    assign unused_nz = a1_nz;

    assign out_valid  = out_valid_reg;
    assign kind       = o_kind_reg;
    assign channel    = o_ch_reg;
    assign data_value = o_val_reg;
    assign text_byte  = o_text_reg;
    assign text_valid = o_tv_reg;
    assign last       = o_last_reg;

endmodule
